>>> rtl/core/rpu_pkg.sv
`default_nettype none

package rpu_pkg;

    localparam int PAL_DEPTH = 256;
    localparam int PAL_AW    = $clog2(PAL_DEPTH);

    localparam logic [3:0] LAYOUT_IDX1     = 4'd0;
    localparam logic [3:0] LAYOUT_IDX2     = 4'd1;
    localparam logic [3:0] LAYOUT_IDX4     = 4'd2;
    localparam logic [3:0] LAYOUT_IDX8     = 4'd3;
    localparam logic [3:0] LAYOUT_IDX8A    = 4'd4;
    localparam logic [3:0] LAYOUT_RGB16    = 4'd5;
    localparam logic [3:0] LAYOUT_RGB24    = 4'd6;
    localparam logic [3:0] LAYOUT_RGB32    = 4'd7;
    localparam logic [3:0] LAYOUT_ARGB_STR = 4'd8;
    localparam logic [3:0] LAYOUT_ARGB_PRE = 4'd9;

    localparam logic [2:0] CFG_LAYOUT      = 3'd0;
    localparam logic [2:0] CFG_RED_MASK    = 3'd1;
    localparam logic [2:0] CFG_GREEN_MASK  = 3'd2;
    localparam logic [2:0] CFG_BLUE_MASK   = 3'd3;
    localparam logic [2:0] CFG_RED_PLACE   = 3'd4;
    localparam logic [2:0] CFG_GREEN_PLACE = 3'd5;
    localparam logic [2:0] CFG_BLUE_PLACE  = 3'd6;
    localparam logic [2:0] CFG_ALPHA_PLACE = 3'd7;

    localparam logic OP_PIXEL     = 1'b0;
    localparam logic OP_PAL_WRITE = 1'b1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    typedef struct packed {
        logic        op;
        logic [31:0] source_bytes;
        logic [3:0]  pixel_count;
        logic [7:0]  entry_index;
        logic [31:0] entry_color;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last_of_item;
    } t_out_item;

    function automatic logic [7:0] byte_at(input logic [31:0] src, input logic [1:0] place);
        return src[{place, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] premul(input logic [7:0] a, input logic [7:0] c);
        logic [8:0]  a9;
        logic [16:0] prod;
        a9   = {1'b0, a} + {8'd0, a[7]};
        prod = a9 * {1'b0, c};
        return prod[15:8];
    endfunction

    function automatic logic [7:0] mask_shift(input logic [15:0] w, input logic [15:0] m,
                                              input logic [3:0] sh);
        logic [31:0] v;
        v = {16'd0, w & m} << sh;
        return v[15:8];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/raster_pixel_unpacker.sv
// raster_pixel_unpacker
// Converts scanline source units to premultiplied 8-bit RGBA pixels.
// Input channel: i_in_valid / o_in_stall with i_in_item. An item either
//   writes one palette entry (no result) or carries one source unit.
// Output channel: o_out_valid / i_out_stall with o_out_item, one transfer
//   per pixel; last_of_item marks the final pixel of a source unit.
// Config channel: i_cfg_valid / o_cfg_ready, index and data; always ready.
//   Write registers only while no pixel is in flight.
// Throughput: one source unit per cycle for single-pixel layouts unless the
//   receiver stalls; a packed byte issues its pixels one at a time, set by
//   the single palette read port.
// Pipeline: item register, palette read register, output register. When
//   the receiver stalls, the output register holds and the stall backs up
//   through the pipeline to o_in_stall.
// Reset: clears the pipeline and the config registers to their defaults;
//   palette contents are undefined until written.
`default_nettype none

module raster_pixel_unpacker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire rpu_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output rpu_pkg::t_out_item      o_out_item,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data
);
    import rpu_pkg::*;

    logic [4:0]  r_layout_code;
    logic [15:0] r_red_mask, r_green_mask, r_blue_mask;
    logic [3:0]  r_red_place, r_green_place, r_blue_place;
    logic [1:0]  r_alpha_place;

    logic [31:0] r_pal [PAL_DEPTH];
    logic [31:0] r_pal_q;

    logic        r_s1_v;
    logic [31:0] r_s1_src;
    logic [3:0]  r_s1_cnt;
    logic [2:0]  r_s1_pos;

    logic        r_s2_v;
    logic [31:0] r_s2_src;
    logic        r_s2_last;

    logic        r_out_v;
    t_out_item   r_out;

    logic [3:0]        layout;
    logic              msb;
    logic              in_accept, out_free, s2_go, s2_free, issue, s1_last;
    logic [3:0]        n_cnt;
    logic [7:0]        rd_idx;
    logic [7:0]        pk_byte;
    logic [2:0]        bit_sel;
    logic [1:0]        pair_sel;
    logic              nib_sel;
    logic [15:0]       w16;
    logic [31:0]       s24;
    logic [7:0]        a_src;
    t_out_item         n_out;

    assign layout      = r_layout_code[3:0];
    assign msb         = r_layout_code[4];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout_code <= 5'd7;
            r_red_mask    <= 16'hF800;
            r_green_mask  <= 16'h07E0;
            r_blue_mask   <= 16'h001F;
            r_red_place   <= 4'd2;
            r_green_place <= 4'd1;
            r_blue_place  <= 4'd0;
            r_alpha_place <= 2'd3;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LAYOUT:      r_layout_code <= i_cfg_data[4:0];
                CFG_RED_MASK:    r_red_mask    <= i_cfg_data;
                CFG_GREEN_MASK:  r_green_mask  <= i_cfg_data;
                CFG_BLUE_MASK:   r_blue_mask   <= i_cfg_data;
                CFG_RED_PLACE:   r_red_place   <= i_cfg_data[3:0];
                CFG_GREEN_PLACE: r_green_place <= i_cfg_data[3:0];
                CFG_BLUE_PLACE:  r_blue_place  <= i_cfg_data[3:0];
                CFG_ALPHA_PLACE: r_alpha_place <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign out_free   = !r_out_v || !i_out_stall;
    assign s2_go      = r_s2_v && out_free;
    assign s2_free    = !r_s2_v || s2_go;
    assign issue      = r_s1_v && s2_free;
    assign s1_last    = (({1'b0, r_s1_pos} + 4'd1) == r_s1_cnt);
    assign o_in_stall = r_s1_v && !(issue && s1_last);
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        unique case (layout)
            LAYOUT_IDX1:  n_cnt = (i_in_item.pixel_count > 4'd8) ? 4'd8
                                                                 : i_in_item.pixel_count;
            LAYOUT_IDX2:  n_cnt = (i_in_item.pixel_count > 4'd4) ? 4'd4
                                                                 : i_in_item.pixel_count;
            LAYOUT_IDX4:  n_cnt = (i_in_item.pixel_count > 4'd2) ? 4'd2
                                                                 : i_in_item.pixel_count;
            LAYOUT_IDX8:  n_cnt = (i_in_item.pixel_count > 4'd1) ? 4'd1
                                                                 : i_in_item.pixel_count;
            LAYOUT_IDX8A, LAYOUT_RGB16, LAYOUT_RGB24, LAYOUT_RGB32,
            LAYOUT_ARGB_STR, LAYOUT_ARGB_PRE: n_cnt = 4'd1;
            default:      n_cnt = 4'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (in_accept && i_in_item.op == OP_PIXEL && n_cnt != 4'd0) begin
            r_s1_v <= 1'b1;
        end else if (issue && s1_last) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_in_item.op == OP_PIXEL) begin
            r_s1_src <= i_in_item.source_bytes;
            r_s1_cnt <= n_cnt;
            r_s1_pos <= 3'd0;
        end else if (issue) begin
            r_s1_pos <= r_s1_pos + 3'd1;
        end
    end

    always_comb begin
        pk_byte  = r_s1_src[7:0];
        bit_sel  = msb ? (3'd7 - r_s1_pos) : r_s1_pos;
        pair_sel = msb ? (2'd3 - r_s1_pos[1:0]) : r_s1_pos[1:0];
        nib_sel  = msb ? !r_s1_pos[0] : r_s1_pos[0];
        case (layout)
            LAYOUT_IDX1: rd_idx = {7'd0, pk_byte[bit_sel]};
            LAYOUT_IDX2: rd_idx = {6'd0, pk_byte[{pair_sel, 1'b0} +: 2]};
            LAYOUT_IDX4: rd_idx = {4'd0, pk_byte[{nib_sel, 2'b00} +: 4]};
            default:     rd_idx = pk_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_in_item.op == OP_PAL_WRITE) begin
            r_pal[i_in_item.entry_index[PAL_AW-1:0]] <= i_in_item.entry_color;
        end
        if (issue) begin
            r_pal_q <= r_pal[rd_idx[PAL_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (issue) begin
            r_s2_v <= 1'b1;
        end else if (s2_go) begin
            r_s2_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s2_src  <= r_s1_src;
            r_s2_last <= s1_last;
        end
    end

    always_comb begin
        w16   = msb ? {r_s2_src[7:0], r_s2_src[15:8]} : r_s2_src[15:0];
        s24   = {8'd0, r_s2_src[23:0]};
        a_src = byte_at(r_s2_src, r_alpha_place);
        n_out.last_of_item = r_s2_last;
        case (layout)
            LAYOUT_IDX8A: begin
                n_out.red   = premul(r_s2_src[15:8], r_pal_q[23:16]);
                n_out.green = premul(r_s2_src[15:8], r_pal_q[15:8]);
                n_out.blue  = premul(r_s2_src[15:8], r_pal_q[7:0]);
                n_out.alpha = r_s2_src[15:8];
            end
            LAYOUT_RGB16: begin
                n_out.red   = mask_shift(w16, r_red_mask, r_red_place);
                n_out.green = mask_shift(w16, r_green_mask, r_green_place);
                n_out.blue  = mask_shift(w16, r_blue_mask, r_blue_place);
                n_out.alpha = ALPHA_OPAQUE;
            end
            LAYOUT_RGB24: begin
                n_out.red   = byte_at(s24, r_red_place[1:0]);
                n_out.green = byte_at(s24, r_green_place[1:0]);
                n_out.blue  = byte_at(s24, r_blue_place[1:0]);
                n_out.alpha = ALPHA_OPAQUE;
            end
            LAYOUT_RGB32: begin
                n_out.red   = byte_at(r_s2_src, r_red_place[1:0]);
                n_out.green = byte_at(r_s2_src, r_green_place[1:0]);
                n_out.blue  = byte_at(r_s2_src, r_blue_place[1:0]);
                n_out.alpha = ALPHA_OPAQUE;
            end
            LAYOUT_ARGB_STR: begin
                n_out.red   = premul(a_src, byte_at(r_s2_src, r_red_place[1:0]));
                n_out.green = premul(a_src, byte_at(r_s2_src, r_green_place[1:0]));
                n_out.blue  = premul(a_src, byte_at(r_s2_src, r_blue_place[1:0]));
                n_out.alpha = a_src;
            end
            LAYOUT_ARGB_PRE: begin
                n_out.red   = byte_at(r_s2_src, r_red_place[1:0]);
                n_out.green = byte_at(r_s2_src, r_green_place[1:0]);
                n_out.blue  = byte_at(r_s2_src, r_blue_place[1:0]);
                n_out.alpha = a_src;
            end
            default: begin
                n_out.red   = r_pal_q[23:16];
                n_out.green = r_pal_q[15:8];
                n_out.blue  = r_pal_q[7:0];
                n_out.alpha = r_pal_q[31:24];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s2_go) begin
            r_out_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

>>> rtl/core/rpu_checker.sv
`default_nettype none

module rpu_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire rpu_pkg::t_out_item o_out_item,
    input wire logic               i_cfg_valid,
    input wire logic               o_cfg_ready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("output transfer dropped or changed while stalled");

    a_rst_out_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_rst_in_free: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

    a_handshake_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({o_in_stall, o_out_valid}))
        else $error("handshake output unknown out of reset");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config write held off");

endmodule

bind raster_pixel_unpacker rpu_checker u_rpu_checker (.*);

`default_nettype wire

>>> sim/tb_raster_pixel_unpacker.sv
`timescale 1ns / 1ps

module tb_raster_pixel_unpacker;
    import rpu_pkg::*;

    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 6;
    localparam int RAND_PHASES   = 8;
    localparam int RAND_ITEMS    = 12;

    typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN, RX_HEAVY} rx_mode_e;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_item    in_item = '0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    wire         o_in_stall;
    wire         o_out_valid;
    wire         o_cfg_ready;
    t_out_item   o_out_item;

    raster_pixel_unpacker dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_item (o_out_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow of the block's registers and palette
    logic [4:0]  fmt_code = {1'b0, LAYOUT_RGB32};
    logic [15:0] r_mask = 16'hF800;
    logic [15:0] g_mask = 16'h07E0;
    logic [15:0] b_mask = 16'h001F;
    logic [3:0]  r_sh = 4'd2;
    logic [3:0]  g_sh = 4'd1;
    logic [3:0]  b_sh = 4'd0;
    logic [1:0]  a_sel = 2'd3;
    logic [31:0] clut [PAL_DEPTH];

    logic [3:0] packed_fmts [4] = '{LAYOUT_IDX1, LAYOUT_IDX2, LAYOUT_IDX4, LAYOUT_IDX8};
    logic [3:0] all_fmts [10] = '{LAYOUT_IDX1, LAYOUT_IDX2, LAYOUT_IDX4, LAYOUT_IDX8,
                                  LAYOUT_IDX8A, LAYOUT_RGB16, LAYOUT_RGB24, LAYOUT_RGB32,
                                  LAYOUT_ARGB_STR, LAYOUT_ARGB_PRE};

    t_out_item pixel_q [$];
    t_out_item want;

    int       n_bad = 0;
    int       pixels_checked = 0;
    int       units_sent = 0;
    int       entries_written = 0;
    int       reg_writes = 0;
    int       held_offers = 0;
    int       burst_left = 0;
    int       gap_max = 0;
    int       hold_req = 0;
    int       hold_left = 0;
    rx_mode_e stall_mode = RX_FREE;
    logic [7:0] stall_pat = 8'b0110_0100;

    function automatic void note_failure(input string msg);
        n_bad++;
        if (n_bad <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    function automatic logic [7:0] alpha_scale(input logic [7:0] a, input logic [7:0] c);
        logic [31:0] prod;
        prod = ({24'd0, a} + {31'd0, a[7]}) * {24'd0, c};
        return prod[15:8];
    endfunction

    function automatic logic [7:0] masked_shift(input logic [15:0] w, input logic [15:0] m,
                                                input logic [3:0] sh);
        logic [31:0] v;
        v = 32'(w & m);
        v = v << sh;
        return v[15:8];
    endfunction

    function automatic logic [7:0] pick_byte(input logic [31:0] s, input logic [1:0] sel);
        return 8'(s >> (8 * sel));
    endfunction

    function automatic logic [31:0] clut_read(input logic [7:0] idx);
        return (idx < PAL_DEPTH) ? clut[idx] : 32'd0;
    endfunction

    function automatic t_out_item make_px(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b, input logic [7:0] a,
                                          input logic last);
        t_out_item px;
        px.red = r;
        px.green = g;
        px.blue = b;
        px.alpha = a;
        px.last_of_item = last;
        return px;
    endfunction

    // works out the pixels one accepted transfer produces
    function automatic void predict_pixels(input t_in_item it);
        logic [3:0]  fmt;
        logic        msb_first;
        int          bpp, limit, cnt, sh, i;
        logic [7:0]  idx, a;
        logic [31:0] e, s;
        logic [15:0] w;
        fmt = fmt_code[3:0];
        msb_first = fmt_code[4];
        if (it.op == OP_PAL_WRITE) begin
            if (it.entry_index < PAL_DEPTH)
                clut[it.entry_index] = it.entry_color;
            return;
        end
        s = it.source_bytes;
        case (fmt)
            LAYOUT_IDX1, LAYOUT_IDX2, LAYOUT_IDX4, LAYOUT_IDX8: begin
                bpp = 1 << fmt;
                limit = 8 / bpp;
                cnt = (int'(it.pixel_count) > limit) ? limit : int'(it.pixel_count);
                for (i = 0; i < cnt; i++) begin
                    sh = msb_first ? (8 - bpp - i * bpp) : (i * bpp);
                    idx = 8'((s[7:0] >> sh) & ((1 << bpp) - 1));
                    e = clut_read(idx);
                    pixel_q.push_back(make_px(e[23:16], e[15:8], e[7:0], e[31:24],
                                              i == cnt - 1));
                end
            end
            LAYOUT_IDX8A: begin
                e = clut_read(s[7:0]);
                a = s[15:8];
                pixel_q.push_back(make_px(alpha_scale(a, e[23:16]), alpha_scale(a, e[15:8]),
                                          alpha_scale(a, e[7:0]), a, 1'b1));
            end
            LAYOUT_RGB16: begin
                w = msb_first ? {s[7:0], s[15:8]} : s[15:0];
                pixel_q.push_back(make_px(masked_shift(w, r_mask, r_sh),
                                          masked_shift(w, g_mask, g_sh),
                                          masked_shift(w, b_mask, b_sh), ALPHA_OPAQUE, 1'b1));
            end
            LAYOUT_RGB24, LAYOUT_RGB32: begin
                if (fmt == LAYOUT_RGB24)
                    s[31:24] = 8'h00;
                pixel_q.push_back(make_px(pick_byte(s, r_sh[1:0]), pick_byte(s, g_sh[1:0]),
                                          pick_byte(s, b_sh[1:0]), ALPHA_OPAQUE, 1'b1));
            end
            LAYOUT_ARGB_STR: begin
                a = pick_byte(s, a_sel);
                pixel_q.push_back(make_px(alpha_scale(a, pick_byte(s, r_sh[1:0])),
                                          alpha_scale(a, pick_byte(s, g_sh[1:0])),
                                          alpha_scale(a, pick_byte(s, b_sh[1:0])), a, 1'b1));
            end
            LAYOUT_ARGB_PRE: begin
                pixel_q.push_back(make_px(pick_byte(s, r_sh[1:0]), pick_byte(s, g_sh[1:0]),
                                          pick_byte(s, b_sh[1:0]), pick_byte(s, a_sel), 1'b1));
            end
            default: ;
        endcase
    endfunction

    function automatic t_in_item pixel_unit(input logic [31:0] src, input logic [3:0] cnt);
        t_in_item it;
        it.op = OP_PIXEL;
        it.source_bytes = src;
        it.pixel_count = cnt;
        it.entry_index = 8'($urandom);
        it.entry_color = $urandom;
        return it;
    endfunction

    function automatic t_in_item entry_write(input logic [7:0] idx, input logic [31:0] color);
        t_in_item it;
        it.op = OP_PAL_WRITE;
        it.source_bytes = $urandom;
        it.pixel_count = 4'($urandom);
        it.entry_index = idx;
        it.entry_color = color;
        return it;
    endfunction

    function automatic logic [15:0] reg_value();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid = 1'b1;
        in_item = it;
        do @(posedge clk); while (o_in_stall);
        predict_pixels(it);
        if (it.op == OP_PAL_WRITE)
            entries_written++;
        else
            units_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge clk); while (!o_cfg_ready);
        case (idx)
            CFG_LAYOUT:      fmt_code = data[4:0];
            CFG_RED_MASK:    r_mask = data;
            CFG_GREEN_MASK:  g_mask = data;
            CFG_BLUE_MASK:   b_mask = data;
            CFG_RED_PLACE:   r_sh = data[3:0];
            CFG_GREEN_PLACE: g_sh = data[3:0];
            CFG_BLUE_PLACE:  b_sh = data[3:0];
            CFG_ALPHA_PLACE: a_sel = data[1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // stop offering, wait for every pending pixel, then let the pipeline empty
    task automatic settle();
        int waited;
        waited = 0;
        @(negedge clk);
        in_valid = 1'b0;
        burst_left = 0;
        while (pixel_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        if (pixel_q.size() != 0) begin
            note_failure($sformatf("%0d expected pixels never arrived", pixel_q.size()));
            pixel_q.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // receiver
    always @(negedge clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0) begin
            out_stall = 1'b1;
            hold_left--;
        end else begin
            case (stall_mode)
                RX_RANDOM:  out_stall = ($urandom_range(0, 3) == 0);
                RX_PATTERN: begin
                    stall_pat = {stall_pat[0], stall_pat[7:1]};
                    out_stall = stall_pat[0];
                end
                RX_HEAVY:   out_stall = ($urandom_range(0, 9) < 7);
                default:    out_stall = 1'b0;
            endcase
        end
    end

    // pixel checker
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && o_in_stall)
                held_offers++;
            if (o_out_valid && !out_stall) begin
                if (pixel_q.size() == 0) begin
                    note_failure($sformatf("unexpected pixel r %02h g %02h b %02h a %02h last %0b",
                                           o_out_item.red, o_out_item.green, o_out_item.blue,
                                           o_out_item.alpha, o_out_item.last_of_item));
                end else begin
                    want = pixel_q.pop_front();
                    pixels_checked++;
                    if (o_out_item.red !== want.red || o_out_item.green !== want.green ||
                        o_out_item.blue !== want.blue || o_out_item.alpha !== want.alpha ||
                        o_out_item.last_of_item !== want.last_of_item)
                        note_failure({
                            $sformatf("pixel exp r %02h g %02h b %02h a %02h last %0b",
                                      want.red, want.green, want.blue, want.alpha,
                                      want.last_of_item),
                            $sformatf(", got r %02h g %02h b %02h a %02h last %0b",
                                      o_out_item.red, o_out_item.green, o_out_item.blue,
                                      o_out_item.alpha, o_out_item.last_of_item)});
                end
            end
        end
    end

    task automatic test_reset_defaults();
        stall_mode = RX_FREE;
        gap_max = 0;
        send_item(pixel_unit(32'h0000_0000, 4'd0));
        send_item(pixel_unit(32'hFFFF_FFFF, 4'd15));
        send_item(pixel_unit(32'h1234_5678, 4'd3));
    endtask

    task automatic test_palette_load();
        int i;
        logic [31:0] color;
        stall_mode = RX_RANDOM;
        gap_max = 2;
        for (i = 0; i < PAL_DEPTH; i++) begin
            if (i == 0)
                color = 32'h0000_0000;
            else if (i == PAL_DEPTH - 1)
                color = 32'hFFFF_FFFF;
            else
                color = $urandom;
            send_item(entry_write(8'(i), color));
        end
    endtask

    task automatic test_packed_indexed();
        int msb;
        stall_mode = RX_RANDOM;
        gap_max = 3;
        foreach (packed_fmts[f]) begin
            for (msb = 0; msb < 2; msb++) begin
                settle();
                write_reg(CFG_LAYOUT, {11'd0, 1'(msb), packed_fmts[f]});
                send_item(pixel_unit({24'($urandom), (msb != 0) ? 8'h1E : 8'hA5}, 4'd15));
            end
        end
        settle();
        write_reg(CFG_LAYOUT, {11'd0, 1'b0, LAYOUT_IDX1});
        send_item(pixel_unit(32'h0000_00FF, 4'd0));
        send_item(pixel_unit({24'($urandom), 8'h6C}, 4'd3));
    endtask

    task automatic test_indexed_alpha();
        settle();
        write_reg(CFG_LAYOUT, {11'd0, 1'b0, LAYOUT_IDX8A});
        send_item(pixel_unit({16'($urandom), 8'h00, 8'h00}, 4'd0));
        send_item(pixel_unit({16'($urandom), 8'h80, 8'hFF}, 4'd8));
        send_item(pixel_unit({16'($urandom), 8'hFF, 8'h5A}, 4'd15));
    endtask

    task automatic test_rgb16();
        settle();
        write_reg(CFG_LAYOUT, {11'd0, 1'b0, LAYOUT_RGB16});
        send_item(pixel_unit(32'hABCD_F81F, 4'd0));
        settle();
        write_reg(CFG_LAYOUT, {11'd0, 1'b1, LAYOUT_RGB16});
        write_reg(CFG_RED_MASK, 16'hFFFF);
        write_reg(CFG_GREEN_MASK, 16'hFFFF);
        write_reg(CFG_BLUE_MASK, 16'hFFFF);
        write_reg(CFG_RED_PLACE, 16'd15);
        write_reg(CFG_GREEN_PLACE, 16'd0);
        write_reg(CFG_BLUE_PLACE, 16'd8);
        send_item(pixel_unit(32'h0000_8001, 4'd0));
        send_item(pixel_unit(32'hFFFF_FFFF, 4'd0));
    endtask

    task automatic test_byte_placed();
        settle();
        write_reg(CFG_LAYOUT, {11'd0, 1'b1, LAYOUT_RGB24});
        write_reg(CFG_RED_PLACE, 16'd3);
        write_reg(CFG_GREEN_PLACE, 16'd14);
        write_reg(CFG_BLUE_PLACE, 16'd0);
        send_item(pixel_unit(32'hFFFF_FFFF, 4'd0));
        send_item(pixel_unit(32'h1122_3344, 4'd0));
        settle();
        write_reg(CFG_LAYOUT, {11'd0, 1'b0, LAYOUT_ARGB_STR});
        write_reg(CFG_RED_PLACE, 16'd2);
        write_reg(CFG_GREEN_PLACE, 16'd1);
        write_reg(CFG_ALPHA_PLACE, 16'd3);
        send_item(pixel_unit(32'h00FF_8001, 4'd0));
        send_item(pixel_unit(32'h7FFF_8001, 4'd0));
        send_item(pixel_unit(32'h80FF_8001, 4'd0));
        send_item(pixel_unit(32'hFFFF_8001, 4'd0));
        settle();
        write_reg(CFG_LAYOUT, {11'd0, 1'b0, LAYOUT_ARGB_PRE});
        write_reg(CFG_ALPHA_PLACE, 16'd0);
        send_item(pixel_unit(32'h1122_3344, 4'd0));
    endtask

    task automatic test_no_result();
        settle();
        write_reg(CFG_LAYOUT, {11'd0, 1'b0, LAYOUT_ARGB_PRE + 4'd1});
        send_item(pixel_unit($urandom, 4'd8));
        settle();
        write_reg(CFG_LAYOUT, 16'h001F);
        send_item(pixel_unit($urandom, 4'd1));
    endtask

    // receiver holds off long enough for the pipeline to back up into the input
    task automatic test_backpressure();
        int i;
        settle();
        write_reg(CFG_LAYOUT, {11'd0, 1'b0, LAYOUT_IDX1});
        stall_mode = RX_FREE;
        gap_max = 0;
        hold_req = 120;
        for (i = 0; i < 30; i++)
            send_item(pixel_unit($urandom, 4'd8));
    endtask

    task automatic test_random_traffic();
        int phase, k;
        logic [4:0] code;
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            settle();
            code = {1'($urandom), all_fmts[$urandom_range(0, 9)]};
            if ($urandom_range(0, 7) == 0)
                code = 5'($urandom);
            write_reg(CFG_LAYOUT, {11'($urandom), code});
            if (phase < 2) begin
                write_reg(CFG_RED_MASK, (phase == 0) ? 16'hFFFF : 16'h0000);
                write_reg(CFG_GREEN_MASK, (phase == 0) ? 16'hFFFF : 16'h0000);
                write_reg(CFG_BLUE_MASK, (phase == 0) ? 16'hFFFF : 16'h0000);
                write_reg(CFG_RED_PLACE, (phase == 0) ? 16'hFFFF : 16'h0000);
                write_reg(CFG_GREEN_PLACE, (phase == 0) ? 16'hFFFF : 16'h0000);
                write_reg(CFG_BLUE_PLACE, (phase == 0) ? 16'hFFFF : 16'h0000);
                write_reg(CFG_ALPHA_PLACE, (phase == 0) ? 16'hFFFF : 16'h0000);
            end else begin
                write_reg(CFG_RED_MASK, reg_value());
                write_reg(CFG_GREEN_MASK, reg_value());
                write_reg(CFG_BLUE_MASK, reg_value());
                write_reg(CFG_RED_PLACE, reg_value());
                write_reg(CFG_GREEN_PLACE, reg_value());
                write_reg(CFG_BLUE_PLACE, reg_value());
                write_reg(CFG_ALPHA_PLACE, reg_value());
            end
            stall_mode = rx_mode_e'($urandom_range(0, 3));
            stall_pat = 8'($urandom) & 8'h7F;
            case ($urandom_range(0, 2))
                0: gap_max = 0;
                1: gap_max = 2;
                default: gap_max = 8;
            endcase
            for (k = 0; k < RAND_ITEMS; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_item(entry_write(8'($urandom), $urandom));
                else
                    send_item(pixel_unit($urandom, 4'($urandom)));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_reset_defaults();
        test_palette_load();
        test_packed_indexed();
        test_indexed_alpha();
        test_rgb16();
        test_byte_placed();
        test_no_result();
        test_backpressure();
        test_random_traffic();
        settle();
        $display("covered every layout, undefined codes and a long receiver hold-off");
        $display("%0d units %0d entries %0d cfg writes %0d pixels %0d held %0d failures",
                 units_sent, entries_written, reg_writes, pixels_checked, held_offers, n_bad);
        if (n_bad == 0)
            $display("tb_raster_pixel_unpacker passed");
        else
            $display("tb_raster_pixel_unpacker failed");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("tb_raster_pixel_unpacker failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/rpu_pkg.sv
rtl/core/raster_pixel_unpacker.sv
rtl/core/rpu_checker.sv
sim/tb_raster_pixel_unpacker.sv
